>>> sv/atcv_pkg.sv
// Shared types and constants for the accelerometer tilt block.
// Holds the arctangent table, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package atcv_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROLL_ZERO  = 2'd0;
  localparam logic [1:0] CFG_PITCH_ZERO = 2'd1;

  // Fixed widths of the angle path
  localparam int CORD_W  = 20;   // CORDIC X and Y, signed
  localparam int ANG_ACC = 26;   // angle accumulator, 8 fraction bits
  localparam int DIFF_W  = 17;   // angle after zero subtraction

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_IDLE        = 13'b0000000000001,
    ST_ROLL_START  = 13'b0000000000010,
    ST_SQ_INIT     = 13'b0000000000100,
    ST_SQRT        = 13'b0000000001000,
    ST_ROLL_WAIT   = 13'b0000000010000,
    ST_PITCH_START = 13'b0000000100000,
    ST_PITCH_WAIT  = 13'b0000001000000,
    ST_WIN_RD      = 13'b0000010000000,
    ST_WIN_UPD     = 13'b0000100000000,
    ST_SET_X       = 13'b0001000000000,
    ST_DIV_X       = 13'b0010000000000,
    ST_SET_Y       = 13'b0100000000000,
    ST_DIV_Y       = 13'b1000000000000
  } atcv_state_t;

  // Status of the CORDIC unit as seen by the sequencer
  typedef struct packed {
    logic        busy;
    logic [14:0] angle;
  } atcv_cord_stat_t;

  // atan(2^-i) in binary angle units with 8 fraction bits
  function automatic logic [21:0] atan_val(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:    v = 22'd2097152;
      5'd1:    v = 22'd1238021;
      5'd2:    v = 22'd654136;
      5'd3:    v = 22'd332050;
      5'd4:    v = 22'd166669;
      5'd5:    v = 22'd83416;
      5'd6:    v = 22'd41718;
      5'd7:    v = 22'd20860;
      5'd8:    v = 22'd10430;
      5'd9:    v = 22'd5215;
      5'd10:   v = 22'd2608;
      5'd11:   v = 22'd1304;
      5'd12:   v = 22'd652;
      5'd13:   v = 22'd326;
      5'd14:   v = 22'd163;
      5'd15:   v = 22'd81;
      5'd16:   v = 22'd41;
      5'd17:   v = 22'd20;
      5'd18:   v = 22'd10;
      5'd19:   v = 22'd5;
      5'd20:   v = 22'd3;
      5'd21:   v = 22'd1;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/atcv_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle.
// Returns the angle of a first-quadrant vector in units 0..16384.
// Depends on atcv_pkg.
`default_nettype none

module atcv_cordic #(
  parameter int STEPS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire signed [atcv_pkg::CORD_W-1:0]  x_in,
  input  wire signed [atcv_pkg::CORD_W-1:0]  y_in,
  output atcv_pkg::atcv_cord_stat_t          stat
);
  import atcv_pkg::*;

  logic                      busy_r;
  logic [4:0]                cnt_r;
  logic                      zero_r;
  logic signed [CORD_W-1:0]  x_r;
  logic signed [CORD_W-1:0]  y_r;
  logic signed [ANG_ACC-1:0] a_r;

  logic signed [CORD_W-1:0]  dx;
  logic signed [CORD_W-1:0]  dy;
  logic signed [ANG_ACC-1:0] step_ang;
  logic signed [ANG_ACC-1:0] rnd;
  logic signed [ANG_ACC-1:0] whole;

  // Shifted operands and table value for the current micro-rotation
  always_comb begin
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    step_ang = $signed({4'b0, atan_val(cnt_r)});
  end

  // Control: run STEPS rotations after a start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == 5'(STEPS - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  // Datapath: rotate towards the X axis and accumulate the angle
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x_in;
      y_r    <= y_in;
      a_r    <= '0;
      zero_r <= (x_in == '0) && (y_in == '0);
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        a_r <= a_r + step_ang;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        a_r <= a_r - step_ang;
      end
    end
  end

  // Round half up to whole units and clamp to the first quadrant
  always_comb begin
    rnd   = a_r + ANG_ACC'(128);
    whole = rnd >>> 8;
    stat.busy = busy_r;
    if (zero_r || whole < 0) begin
      stat.angle = '0;
    end else if (whole > ANG_ACC'(16384)) begin
      stat.angle = 15'd16384;
    end else begin
      stat.angle = whole[14:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/accel_tilt_to_controller_values_top.sv
// A sample runs through the root, the pitch CORDIC pass and the two eight-step divisions in turn;
// the X division is skipped when roll lies in the dead zone, and the roll pass overlaps the root
// for CORDIC_STEPS up to 17. A new sample is taken only once the previous one is through.
// The result register takes a new item only once the previous result has been transferred;
// until then the last Y division step waits.
// Reset (synchronous, active low) clears the sums, fill count, write slot, zero angles and
// out_valid and sets the last outputs to 255; window entries are only used once written.
`default_nettype none

module accel_tilt_to_controller_values_top #(
  parameter int WINDOW_LEN   = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire signed [7:0] in_accel_down,
  input  wire signed [7:0] in_accel_back,
  input  wire signed [7:0] in_accel_left,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [6:0]       out_tilt_x,
  output logic [6:0]       out_tilt_y,
  input  wire              cfg_we,
  input  wire [1:0]        cfg_index,
  input  wire [15:0]       cfg_wdata
);
  import atcv_pkg::*;

  localparam int SLW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW  = $clog2(WINDOW_LEN + 1);
  localparam int SW  = DIFF_W + SLW;
  localparam int LW  = FW + 13;
  localparam int NW  = LW + 12;

  atcv_state_t state_r;

  // Configuration registers
  logic signed [15:0] roll_zero_r;
  logic signed [15:0] pitch_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_zero_r  <= '0;
      pitch_zero_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROLL_ZERO) begin
        roll_zero_r <= cfg_wdata;
      end
      if (cfg_index == CFG_PITCH_ZERO) begin
        pitch_zero_r <= cfg_wdata;
      end
    end
  end

  // Sample and working registers
  logic signed [7:0]        x_r;
  logic signed [7:0]        y_r;
  logic signed [8:0]        z_r;
  logic [14:0]              ysq_r;
  logic [14:0]              zsq_r;
  logic [31:0]              v_r;
  logic [31:0]              res_r;
  logic [31:0]              bit_r;
  logic signed [DIFF_W-1:0] dr_r;
  logic signed [DIFF_W-1:0] dp_r;
  logic signed [DIFF_W-1:0] old_roll_r;
  logic signed [DIFF_W-1:0] old_pitch_r;
  logic signed [SW-1:0]     roll_sum_r;
  logic signed [SW-1:0]     pitch_sum_r;
  logic [FW-1:0]            fill_r;
  logic [SLW-1:0]           slot_r;
  logic [NW-1:0]            num_r;
  logic [NW-1:0]            den_sh_r;
  logic [7:0]               q_r;
  logic [2:0]               dcnt_r;
  logic [7:0]               tx_r;
  logic [7:0]               last_x_r;
  logic [7:0]               last_y_r;

  // Window memories
  logic signed [DIFF_W-1:0] roll_mem  [WINDOW_LEN];
  logic signed [DIFF_W-1:0] pitch_mem [WINDOW_LEN];

  // CORDIC unit, shared by roll and pitch
  logic                     cord_start;
  logic signed [CORD_W-1:0] cord_x;
  logic signed [CORD_W-1:0] cord_y;
  atcv_cord_stat_t          cord_stat;

  atcv_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x_in  (cord_x),
    .y_in  (cord_y),
    .stat  (cord_stat)
  );

  logic [8:0] abs_x;
  logic [8:0] abs_y;
  logic [8:0] abs_z;

  always_comb begin
    abs_x = (x_r < 0) ? 9'(-x_r) : 9'(x_r);
    abs_y = (y_r < 0) ? 9'(-y_r) : 9'(y_r);
    abs_z = (z_r < 0) ? 9'(-z_r) : 9'(z_r);
    cord_start = (state_r == ST_ROLL_START) || (state_r == ST_PITCH_START);
    if (state_r == ST_ROLL_START) begin
      cord_x = $signed({3'b0, abs_z, 8'b0});
      cord_y = $signed({3'b0, abs_y, 8'b0});
    end else begin
      cord_x = $signed({4'b0, res_r[15:0]});
      cord_y = $signed({3'b0, abs_x, 8'b0});
    end
  end

  // Roll and pitch from the CORDIC angle, less the zero angles
  logic signed [DIFF_W:0] roll_q;
  logic signed [DIFF_W:0] roll_sgn;
  logic signed [DIFF_W:0] roll_cl;
  logic signed [DIFF_W:0] roll_d;
  logic signed [DIFF_W:0] pitch_sgn;
  logic signed [DIFF_W:0] pitch_d;

  always_comb begin
    roll_q = (z_r < 0) ? (18'sd32768 - $signed({3'b0, cord_stat.angle}))
                       : $signed({3'b0, cord_stat.angle});
    roll_sgn = (y_r < 0) ? -roll_q : roll_q;
    roll_cl  = (roll_sgn > 18'sd32767) ? 18'sd32767 : roll_sgn;
    roll_d   = roll_cl - 18'(roll_zero_r);
    pitch_sgn = (x_r > 0) ? -$signed({3'b0, cord_stat.angle})
                          : $signed({3'b0, cord_stat.angle});
    pitch_d   = pitch_sgn - 18'(pitch_zero_r);
  end

  // Square root trial
  logic [31:0] sq_trial;
  assign sq_trial = res_r + bit_r;

  // Mapping of the averages to numerators and denominators
  logic signed [NW:0] lim_e;
  logic signed [NW:0] rsum_e;
  logic signed [NW:0] psum_e;
  logic signed [NW:0] rs_cl;
  logic signed [NW:0] ps_cl;
  logic signed [NW:0] num_hi;
  logic signed [NW:0] num_lo;
  logic signed [NW:0] num_y;
  logic               x_hi;
  logic               x_lo;

  always_comb begin
    lim_e  = $signed({{(NW + 1 - LW){1'b0}}, fill_r, 13'b0});
    rsum_e = (NW + 1)'(roll_sum_r);
    psum_e = (NW + 1)'(pitch_sum_r);
    if (rsum_e > lim_e) begin
      rs_cl = lim_e;
    end else if (rsum_e < -lim_e) begin
      rs_cl = -lim_e;
    end else begin
      rs_cl = rsum_e;
    end
    if (psum_e < 0) begin
      ps_cl = '0;
    end else if (psum_e > lim_e) begin
      ps_cl = lim_e;
    end else begin
      ps_cl = psum_e;
    end
    x_hi   = (3 * rs_cl) > lim_e;
    x_lo   = (3 * rs_cl) < -lim_e;
    num_hi = (NW + 1)'(762 * rs_cl + 258 * lim_e);
    num_lo = (NW + 1)'(762 * rs_cl + 766 * lim_e);
    num_y  = (NW + 1)'(254 * ps_cl + lim_e);
  end

  // Divider trial
  logic       div_ge;
  logic [7:0] q_nxt;
  assign div_ge = num_r >= den_sh_r;
  assign q_nxt  = {q_r[6:0], div_ge};

  // Result offer: only when a value has changed, and held while the last one waits
  logic y_last;
  logic val_chg;
  logic div_hold;
  logic emit;
  assign y_last   = (state_r == ST_DIV_Y) && (dcnt_r == 3'd7);
  assign val_chg  = (tx_r != last_x_r) || (q_nxt != last_y_r);
  assign div_hold = y_last && val_chg && out_valid && !out_ready;
  assign emit     = y_last && val_chg && !div_hold;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      roll_sum_r  <= '0;
      pitch_sum_r <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      last_x_r    <= 8'd255;
      last_y_r    <= 8'd255;
      out_valid   <= 1'b0;
    end else begin
      if (emit) begin
        out_tilt_x <= tx_r[6:0];
        out_tilt_y <= q_nxt[6:0];
        out_valid  <= 1'b1;
        last_x_r   <= tx_r;
        last_y_r   <= q_nxt;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x_r     <= in_accel_back;
            y_r     <= in_accel_left;
            z_r     <= -9'(in_accel_down);
            state_r <= ST_ROLL_START;
          end
        end
        ST_ROLL_START: begin
          ysq_r   <= 15'(y_r * y_r);
          zsq_r   <= 15'(z_r * z_r);
          state_r <= ST_SQ_INIT;
        end
        ST_SQ_INIT: begin
          v_r     <= {16'(ysq_r) + 16'(zsq_r), 16'b0};
          res_r   <= '0;
          bit_r   <= 32'h4000_0000;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (v_r >= sq_trial) begin
            v_r   <= v_r - sq_trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 32'd1) begin
            state_r <= ST_ROLL_WAIT;
          end
        end
        ST_ROLL_WAIT: begin
          if (!cord_stat.busy) begin
            dr_r    <= roll_d[DIFF_W-1:0];
            state_r <= ST_PITCH_START;
          end
        end
        ST_PITCH_START: begin
          state_r <= ST_PITCH_WAIT;
        end
        ST_PITCH_WAIT: begin
          if (!cord_stat.busy) begin
            dp_r    <= pitch_d[DIFF_W-1:0];
            state_r <= ST_WIN_RD;
          end
        end
        ST_WIN_RD: begin
          state_r <= ST_WIN_UPD;
        end
        ST_WIN_UPD: begin
          if (fill_r == FW'(WINDOW_LEN)) begin
            roll_sum_r  <= roll_sum_r - SW'(old_roll_r) + SW'(dr_r);
            pitch_sum_r <= pitch_sum_r - SW'(old_pitch_r) + SW'(dp_r);
          end else begin
            roll_sum_r  <= roll_sum_r + SW'(dr_r);
            pitch_sum_r <= pitch_sum_r + SW'(dp_r);
            fill_r      <= fill_r + FW'(1);
          end
          slot_r  <= (slot_r == SLW'(WINDOW_LEN - 1)) ? '0 : slot_r + SLW'(1);
          state_r <= ST_SET_X;
        end
        ST_SET_X: begin
          dcnt_r <= '0;
          q_r    <= '0;
          if (x_hi) begin
            num_r    <= num_hi[NW-1:0];
            den_sh_r <= NW'({lim_e[NW-1:0], 10'b0});
            state_r  <= ST_DIV_X;
          end else if (x_lo) begin
            num_r    <= num_lo[NW-1:0];
            den_sh_r <= NW'({lim_e[NW-1:0], 10'b0});
            state_r  <= ST_DIV_X;
          end else begin
            tx_r    <= 8'd64;
            state_r <= ST_SET_Y;
          end
        end
        ST_DIV_X: begin
          if (div_ge) begin
            num_r <= num_r - den_sh_r;
          end
          q_r      <= q_nxt;
          den_sh_r <= den_sh_r >> 1;
          dcnt_r   <= dcnt_r + 3'd1;
          if (dcnt_r == 3'd7) begin
            tx_r    <= q_nxt;
            state_r <= ST_SET_Y;
          end
        end
        ST_SET_Y: begin
          dcnt_r   <= '0;
          q_r      <= '0;
          num_r    <= num_y[NW-1:0];
          den_sh_r <= NW'({lim_e[NW-1:0], 8'b0});
          state_r  <= ST_DIV_Y;
        end
        ST_DIV_Y: begin
          // The last step of a changed result waits until the previous result has been transferred
          if (!div_hold) begin
            if (div_ge) begin
              num_r <= num_r - den_sh_r;
            end
            q_r      <= q_nxt;
            den_sh_r <= den_sh_r >> 1;
            dcnt_r   <= dcnt_r + 3'd1;
            if (dcnt_r == 3'd7) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Window read of the outgoing entry and write of the new one
  always_ff @(posedge clk) begin
    if (state_r == ST_WIN_RD) begin
      old_roll_r  <= roll_mem[slot_r];
      old_pitch_r <= pitch_mem[slot_r];
    end
    if (state_r == ST_WIN_UPD) begin
      roll_mem[slot_r]  <= dr_r;
      pitch_mem[slot_r] <= dp_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLW'(WINDOW_LEN - 1))
    else $error("write slot beyond window");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a sample is in progress");

  a_cordic_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PITCH_START) |-> !cord_stat.busy)
    else $error("CORDIC restarted while busy");

endmodule

`default_nettype wire
